// ===== rtl/core/cpt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and microcode for the convex polygon point test
// Holds the command codes, the microprogram table and the control and status
// structs that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // input commands
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // microprogram addresses, in program order
  typedef enum logic [2:0] {
    US_WAIT   = 3'd0,
    US_CHECK  = 3'd1,
    US_READ   = 3'd2,
    US_WRAP   = 3'd3,
    US_DRAIN1 = 3'd4,
    US_DRAIN2 = 3'd5,
    US_DRAIN3 = 3'd6,
    US_RESULT = 3'd7
  } upc_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NOT_QRY  = 3'd1,
    C_EMPTY    = 3'd2,
    C_NOT_LAST = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_t;

  // one control word: datapath strobes, jump condition and jump target
  typedef struct packed {
    logic  in_rdy;
    logic  rd_en;
    logic  wrap_en;
    logic  out_ld;
    cond_t cond;
    upc_t  tgt;
  } ucw_t;

  // datapath status fed back to the sequencer
  typedef struct packed {
    logic qry;
    logic empty;
    logic last;
    logic out_busy;
  } stat_t;

  // microprogram rom; a step with its condition false falls through to the
  // next address, and the last step falls through back to the wait step
  function automatic ucw_t ucode_rom(upc_t a);
    ucw_t w;
    case (a)
      US_WAIT:   w = '{in_rdy: 1'b1, rd_en: 1'b0, wrap_en: 1'b0, out_ld: 1'b0,
                       cond: C_NOT_QRY, tgt: US_WAIT};
      US_CHECK:  w = '{in_rdy: 1'b0, rd_en: 1'b0, wrap_en: 1'b0, out_ld: 1'b0,
                       cond: C_EMPTY, tgt: US_RESULT};
      US_READ:   w = '{in_rdy: 1'b0, rd_en: 1'b1, wrap_en: 1'b0, out_ld: 1'b0,
                       cond: C_NOT_LAST, tgt: US_READ};
      US_WRAP:   w = '{in_rdy: 1'b0, rd_en: 1'b0, wrap_en: 1'b1, out_ld: 1'b0,
                       cond: C_NEVER, tgt: US_WAIT};
      US_RESULT: w = '{in_rdy: 1'b0, rd_en: 1'b0, wrap_en: 1'b0, out_ld: 1'b1,
                       cond: C_OUT_BUSY, tgt: US_RESULT};
      default:   w = '{in_rdy: 1'b0, rd_en: 1'b0, wrap_en: 1'b0, out_ld: 1'b0,
                       cond: C_NEVER, tgt: US_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/cpt_useq.sv =====
// ----------------------------------------------------------------------------
// cpt_useq: microcode sequencer
// Step counter, control word lookup and conditional jump evaluation.
// ----------------------------------------------------------------------------
module cpt_useq import cpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ucw_t  ctrl
);

  upc_t pc_r, pc_nxt;
  logic take;

  always_comb begin
    ctrl = ucode_rom(pc_r);
  end

  always_comb begin
    case (ctrl.cond)
      C_NOT_QRY:  take = !stat.qry;
      C_EMPTY:    take = stat.empty;
      C_NOT_LAST: take = !stat.last;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b0;
    endcase
    // fall through wraps from the result step back to the wait step
    pc_nxt = take ? ctrl.tgt : upc_t'(pc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= US_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/cpt_dpath.sv =====
// ----------------------------------------------------------------------------
// cpt_dpath: vertex store and edge test pipeline
// Vertex memory, vertex count, a three stage edge pipeline (difference,
// cross products, compare) and the result register.
// ----------------------------------------------------------------------------
module cpt_dpath import cpt_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ucw_t                         ctrl,
  output stat_t                        stat,
  input  logic                         in_valid,
  input  logic [1:0]                   in_op,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];

  logic [CW-1:0]                cnt_r;
  logic [AW-1:0]                idx_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic                         rd_v_r, wrap_r;
  logic                         have_first_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [DW-1:0]         dx_r, dy_r, ox_r, oy_r;
  logic                         d_v_r;
  logic signed [PW-1:0]         pa_r, pb_r;
  logic                         m_v_r;
  logic                         outside_r;
  logic                         out_valid_r, out_inside_r;

  logic                         acc, full, wr_en, s1_v, out_ld;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;

  assign acc    = in_valid & ctrl.in_rdy;
  assign full   = (cnt_r == CW'(MAX_VERTICES));
  assign wr_en  = acc & (in_op == OP_APPEND) & !full;
  assign s1_v   = rd_v_r | wrap_r;
  assign cur_x  = wrap_r ? first_x_r : rd_x_r;
  assign cur_y  = wrap_r ? first_y_r : rd_y_r;
  assign out_ld = ctrl.out_ld & (!out_valid_r | out_ready);

  assign stat.qry      = acc & (in_op == OP_QUERY);
  assign stat.empty    = (cnt_r == '0);
  assign stat.last     = (CW'(idx_r) == cnt_r - CW'(1));
  assign stat.out_busy = out_valid_r & !out_ready;

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx_mem[cnt_r[AW-1:0]] <= in_x;
      vy_mem[cnt_r[AW-1:0]] <= in_y;
    end
    if (ctrl.rd_en) begin
      rd_x_r <= vx_mem[idx_r];
      rd_y_r <= vy_mem[idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      idx_r        <= '0;
      rd_v_r       <= 1'b0;
      wrap_r       <= 1'b0;
      have_first_r <= 1'b0;
      d_v_r        <= 1'b0;
      m_v_r        <= 1'b0;
      outside_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (acc && in_op == OP_CLEAR) begin
        cnt_r <= '0;
      end else if (wr_en) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (stat.qry) begin
        idx_r <= '0;
      end else if (ctrl.rd_en) begin
        idx_r <= idx_r + AW'(1);
      end
      rd_v_r <= ctrl.rd_en;
      wrap_r <= ctrl.wrap_en;
      if (stat.qry) begin
        have_first_r <= 1'b0;
      end else if (s1_v) begin
        have_first_r <= 1'b1;
      end
      // an edge exists once a previous vertex is held
      d_v_r <= s1_v & have_first_r;
      m_v_r <= d_v_r;
      if (stat.qry) begin
        outside_r <= 1'b0;
      end else if (m_v_r && pa_r > pb_r) begin
        outside_r <= 1'b1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (stat.qry) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (s1_v) begin
      if (!have_first_r) begin
        first_x_r <= cur_x;
        first_y_r <= cur_y;
      end
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
      dx_r <= $signed({cur_x[COORD_BITS-1], cur_x}) - $signed({prev_x_r[COORD_BITS-1], prev_x_r});
      dy_r <= $signed({cur_y[COORD_BITS-1], cur_y}) - $signed({prev_y_r[COORD_BITS-1], prev_y_r});
      ox_r <= $signed({px_r[COORD_BITS-1], px_r}) - $signed({prev_x_r[COORD_BITS-1], prev_x_r});
      oy_r <= $signed({py_r[COORD_BITS-1], py_r}) - $signed({prev_y_r[COORD_BITS-1], prev_y_r});
    end
    // outside when ox*dy > oy*dx
    if (d_v_r) begin
      pa_r <= ox_r * dy_r;
      pb_r <= oy_r * dx_r;
    end
    if (out_ld) begin
      out_inside_r <= !outside_r;
    end
  end

endmodule

// ===== rtl/core/convex_polygon_point_test.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_point_test: point in convex polygon test
// Clear, append and append-ignored-when-full commands build an ordered vertex
// list; a query reports whether a point is inside or on the boundary. A clear,
// an append or an unused command leaves the input ready for the next command.
// A query on an empty polygon reports inside; the length of any other query
// is set by the single read port of the vertex memory, which the microcode
// loop walks one vertex per cycle, plus the fill and drain of the three stage
// edge pipeline. Commands are taken while a result still waits in the output
// register; a query's result step stalls while that register stays full.
// ----------------------------------------------------------------------------
module convex_polygon_point_test import cpt_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res
);

  ucw_t  ctrl;
  stat_t stat;

  assign in_ready = ctrl.in_rdy;

  cpt_useq u_useq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  cpt_dpath #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_x          (in_x),
    .in_y          (in_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inside_res(out_inside_res)
  );

endmodule

// ===== rtl/core/cpt_checker.sv =====
// ----------------------------------------------------------------------------
// cpt_checker: port level checks for the convex polygon point test
// Watches the handshakes on the top level ports; bound to the top level.
// ----------------------------------------------------------------------------
module cpt_checker import cpt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_inside_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res))
    else $error("result changed while stalled");

  // a query transfer busies the input side
  a_qry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("input ready right after a query");

  // clear, append and unused commands leave the input ready in the next cycle
  a_cmd_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != OP_QUERY |=> in_ready)
    else $error("input ready dropped after a non-query command");

  // a result is only produced while a query is in progress
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no query in progress");

endmodule

bind convex_polygon_point_test cpt_checker u_cpt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_inside_res(out_inside_res)
);
